>>> rtl/hbms_pkg.sv
package hbms_pkg;

  // descriptor and field widths
  localparam int unsigned DescW    = 256;
  localparam int unsigned WordW    = 64;
  localparam int unsigned NumWords = DescW / WordW;
  localparam int unsigned IdxW     = 12;
  localparam int unsigned DistW    = 9;
  localparam int unsigned ThrW     = 8;

  // stream packing
  localparam int unsigned InFieldW  = DescW + IdxW;
  localparam int unsigned InDataW   = ((InFieldW + 7) / 8) * 8;
  localparam int unsigned OutFieldW = IdxW + DistW + 1;
  localparam int unsigned OutDataW  = ((OutFieldW + 7) / 8) * 8;
  localparam int unsigned UserW     = 2;
  localparam int unsigned UserActionBit = 0;
  localparam int unsigned UserSkipBit   = 1;

  // feature index range check
  localparam int unsigned MaxFeatures = 4096;
  localparam int unsigned IdxExtW     = 17;

  localparam logic [DistW-1:0] NoMatchDist    = DistW'(256);
  localparam logic [ThrW-1:0]  ThresholdReset = ThrW'(100);

  typedef enum logic {
    ActLoad = 1'b0,
    ActCand = 1'b1
  } action_e;

  typedef struct packed {
    action_e         action;
    logic            skip;
    logic            last;
    logic [IdxW-1:0] cand_index;
  } item_t;

  typedef struct packed {
    logic             found;
    logic [DistW-1:0] best_distance;
    logic [IdxW-1:0]  best_index;
  } result_t;

endpackage

>>> rtl/hbms_popcount.sv
module hbms_popcount (
  input  logic [hbms_pkg::DescW-1:0] vec_i,
  output logic [hbms_pkg::DistW-1:0] count_o
);

  localparam int unsigned NumBytes = hbms_pkg::DescW / 8;

  function automatic logic [3:0] byte_count(input logic [7:0] b);
    logic [3:0] acc;
    acc = 4'd0;
    for (int k = 0; k < 8; k++) begin
      acc = acc + 4'(b[k]);
    end
    return acc;
  endfunction

  logic [3:0] c8   [NumBytes];
  logic [4:0] c16  [NumBytes/2];
  logic [5:0] c32  [NumBytes/4];
  logic [6:0] c64  [NumBytes/8];
  logic [7:0] c128 [NumBytes/16];

  // adder tree, one level per stage of width growth
  always_comb begin
    for (int i = 0; i < NumBytes; i++) begin
      c8[i] = byte_count(vec_i[8*i +: 8]);
    end
    for (int i = 0; i < NumBytes/2; i++) begin
      c16[i] = 5'(c8[2*i]) + 5'(c8[2*i+1]);
    end
    for (int i = 0; i < NumBytes/4; i++) begin
      c32[i] = 6'(c16[2*i]) + 6'(c16[2*i+1]);
    end
    for (int i = 0; i < NumBytes/8; i++) begin
      c64[i] = 7'(c32[2*i]) + 7'(c32[2*i+1]);
    end
    for (int i = 0; i < NumBytes/16; i++) begin
      c128[i] = 8'(c64[2*i]) + 8'(c64[2*i+1]);
    end
  end

  assign count_o = hbms_pkg::DistW'(c128[0]) + hbms_pkg::DistW'(c128[1]);

endmodule

>>> rtl/hbms_tracker.sv
module hbms_tracker #(
  parameter int unsigned MaxFeatures = hbms_pkg::MaxFeatures
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_wr_en_i,
  input  logic [hbms_pkg::ThrW-1:0]   cfg_wr_data_i,
  input  logic                        fire_i,
  input  hbms_pkg::item_t             item_i,
  input  logic [hbms_pkg::DescW-1:0]  desc_i,
  output hbms_pkg::result_t           result_o
);

  logic [hbms_pkg::DescW-1:0] ref_q;
  logic [hbms_pkg::DistW-1:0] best_q, best_d;
  logic [hbms_pkg::IdxW-1:0]  slot_q, slot_d;
  logic [hbms_pkg::ThrW-1:0]  thr_q;
  logic [hbms_pkg::DistW-1:0] ham_dist;
  logic                       in_range;
  logic                       better;
  logic [hbms_pkg::DistW-1:0] cand_best;
  logic [hbms_pkg::IdxW-1:0]  cand_slot;

  hbms_popcount u_popcount (
    .vec_i   (ref_q ^ desc_i),
    .count_o (ham_dist)
  );

  assign in_range = (hbms_pkg::IdxExtW'(item_i.cand_index)
                     < hbms_pkg::IdxExtW'(MaxFeatures));
  // strict compare: earliest of equal distances wins
  assign better    = !item_i.skip && in_range && (ham_dist < best_q);
  assign cand_best = better ? ham_dist : best_q;
  assign cand_slot = better ? item_i.cand_index : slot_q;

  always_comb begin
    best_d = best_q;
    slot_d = slot_q;
    if (fire_i) begin
      if (item_i.action == hbms_pkg::ActLoad || item_i.last) begin
        best_d = hbms_pkg::NoMatchDist;
        slot_d = '0;
      end else begin
        best_d = cand_best;
        slot_d = cand_slot;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ref_q  <= '0;
      best_q <= hbms_pkg::NoMatchDist;
      slot_q <= '0;
      thr_q  <= hbms_pkg::ThresholdReset;
    end else begin
      best_q <= best_d;
      slot_q <= slot_d;
      if (fire_i && item_i.action == hbms_pkg::ActLoad) begin
        ref_q <= desc_i;
      end
      if (cfg_wr_en_i) begin
        thr_q <= cfg_wr_data_i;
      end
    end
  end

  assign result_o.best_index    = cand_slot;
  assign result_o.best_distance = cand_best;
  assign result_o.found         = (cand_best <= hbms_pkg::DistW'(thr_q));

endmodule

>>> rtl/hamming_best_match_selector.sv
// path: a last candidate word passes the input register, then the result register, before its
//   result shows on the master side
// throughput: one word per cycle unless a reporting word waits on a full result register; the xor
//   popcount, compare and best-so-far update are all combinational between the input and result registers
// reset: rst_ni is asynchronous active low; clears valids and reference,
//   best-so-far back to no match, threshold back to 100
module hamming_best_match_selector #(
  parameter int unsigned MaxFeatures = hbms_pkg::MaxFeatures
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // threshold register write
  input  logic                           cfg_wr_en_i,
  input  logic [hbms_pkg::ThrW-1:0]      cfg_wr_data_i,
  // input stream
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  // word0[63:0], word1[127:64], word2[191:128], word3[255:192], cand_index[267:256], pad
  input  logic [hbms_pkg::InDataW-1:0]   s_axis_tdata_i,
  // action[0], skip[1]
  input  logic [hbms_pkg::UserW-1:0]     s_axis_tuser_i,
  input  logic                           s_axis_tlast_i,
  // result stream
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  // best_index[11:0], best_distance[20:12], found[21], pad
  output logic [hbms_pkg::OutDataW-1:0]  m_axis_tdata_o
);

  // input register stage
  logic                       in_v_q;
  hbms_pkg::item_t            in_item_q;
  logic [hbms_pkg::DescW-1:0] in_desc_q;
  logic                       in_accept;
  logic                       in_fire;
  logic                       reports;

  // result register stage
  logic                       out_v_q;
  hbms_pkg::result_t          out_q;
  hbms_pkg::result_t          result;

  // only a candidate marked last produces a word on the master side
  assign reports = (in_item_q.action == hbms_pkg::ActCand) && in_item_q.last;

  // the held word retires unless it reports and the result slot stays occupied
  assign in_fire = in_v_q && (!reports || !out_v_q || m_axis_tready_i);

  // a new word may enter while an older result still waits to be taken
  assign s_axis_tready_o = !in_v_q || in_fire;
  assign in_accept       = s_axis_tvalid_i && s_axis_tready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_v_q <= s_axis_tvalid_i;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_item_q.action     <= hbms_pkg::action_e'(s_axis_tuser_i[hbms_pkg::UserActionBit]);
      in_item_q.skip       <= s_axis_tuser_i[hbms_pkg::UserSkipBit];
      in_item_q.last       <= s_axis_tlast_i;
      in_item_q.cand_index <= s_axis_tdata_i[hbms_pkg::DescW +: hbms_pkg::IdxW];
      in_desc_q            <= s_axis_tdata_i[hbms_pkg::DescW-1:0];
    end
  end

  // popcount, compare and best-so-far tracking
  hbms_tracker #(
    .MaxFeatures (MaxFeatures)
  ) u_tracker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_wr_en_i   (cfg_wr_en_i),
    .cfg_wr_data_i (cfg_wr_data_i),
    .fire_i        (in_fire),
    .item_i        (in_item_q),
    .desc_i        (in_desc_q),
    .result_o      (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (in_fire && reports) begin
      out_v_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && reports) begin
      out_q <= result;
    end
  end

  assign m_axis_tvalid_o = out_v_q;
  assign m_axis_tdata_o  = hbms_pkg::OutDataW'(out_q);

  // a result appears only right after a reporting candidate retired
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_v_q) |-> $past(in_fire && reports))
    else $error("result word without a reporting candidate");

  // a reporting candidate never overwrites a result still waiting
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && reports) |-> (!out_v_q || m_axis_tready_i))
    else $error("pending result overwritten");

  // back-pressure only comes from a held input word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> in_v_q)
    else $error("input stalled with empty input stage");

  // a match is never flagged when nothing was kept
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && out_q.found) |-> (out_q.best_distance != hbms_pkg::NoMatchDist))
    else $error("found set without a kept candidate");

endmodule
